// ===== rtl/core/led_command_merge_framer_top_assert.svh =====
// Assertion macros shared by the checker of the LED command framer.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef LED_COMMAND_MERGE_FRAMER_TOP_ASSERT_SVH
`define LED_COMMAND_MERGE_FRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LCMF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lcmf assertion failed");

// Next-cycle implication, checked outside reset.
`define LCMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lcmf assertion failed");

`endif

// ===== rtl/core/lcmf_pkg.sv =====
package lcmf_pkg;

    // Command word: byte i at index i.
    typedef logic [3:0][7:0] t_cmd;

    // Position of a byte within the frame.
    typedef logic [3:0] t_fidx;

    localparam t_fidx IDX_SYNC0  = 4'd0;
    localparam t_fidx IDX_SYNC1  = 4'd1;
    localparam t_fidx IDX_LEN    = 4'd2;
    localparam t_fidx IDX_CRC_LO = 4'd3;
    localparam t_fidx IDX_CRC_HI = 4'd4;
    localparam t_fidx IDX_PAD0   = 4'd5;
    localparam t_fidx IDX_PAD1   = 4'd6;
    localparam t_fidx IDX_TAG    = 4'd7;
    localparam t_fidx IDX_CMD0   = 4'd8;
    localparam t_fidx IDX_CMD1   = 4'd9;
    localparam t_fidx IDX_CMD2   = 4'd10;
    localparam t_fidx IDX_CMD3   = 4'd11;

    localparam logic [7:0] SYNC0_BYTE = 8'h59;
    localparam logic [7:0] SYNC1_BYTE = 8'hA5;
    localparam logic [7:0] LEN_BYTE   = 8'h0A;
    localparam logic [7:0] PAD_BYTE   = 8'h00;
    localparam logic [7:0] TAG_BYTE   = 8'h01;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // LED modes in byte 3 bits 7:5.
    localparam logic [2:0] MODE_SECOND_A = 3'd0;
    localparam logic [2:0] MODE_FIRST_A  = 3'd1;
    localparam logic [2:0] MODE_MERGED   = 3'd4;
    localparam logic [2:0] MODE_SECOND_B = 3'd5;
    localparam logic [2:0] MODE_FIRST_B  = 3'd6;

    // One byte of reflected CRC-16.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // CRC after the fixed bytes 00 00 01 that precede the command.
    localparam logic [15:0] CRC_PRE =
        crc_step(crc_step(crc_step(CRC_INIT, PAD_BYTE), PAD_BYTE), TAG_BYTE);

endpackage

// ===== rtl/core/lcmf_cmd_if.sv =====
interface lcmf_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] cmd_byte0;
    logic [7:0] cmd_byte1;
    logic [7:0] cmd_byte2;
    logic [7:0] cmd_byte3;

    modport source (output valid, output cmd_byte0, output cmd_byte1,
                    output cmd_byte2, output cmd_byte3, input ready);
    modport sink   (input valid, input cmd_byte0, input cmd_byte1,
                    input cmd_byte2, input cmd_byte3, output ready);
endinterface

// ===== rtl/core/lcmf_frame_if.sv =====
interface lcmf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

// ===== rtl/core/lcmf_front.sv =====
module lcmf_front
    import lcmf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lcmf_cmd_if.sink   i_cmd,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [1:0] r_active;
    t_cmd       r_first;
    t_cmd       r_second;
    logic [1:0] n_active;
    t_cmd       n_first;
    t_cmd       n_second;

    t_cmd       cmd_in;
    t_cmd       cmd_mid;
    logic [2:0] mode;
    logic       is_first;
    logic       is_second;
    logic       is_off;

    assign i_cmd.ready = !i_full;
    assign o_push      = i_cmd.valid && !i_full;

    assign cmd_in    = {i_cmd.cmd_byte3, i_cmd.cmd_byte2, i_cmd.cmd_byte1, i_cmd.cmd_byte0};
    assign mode      = cmd_in[3][7:5];
    assign is_first  = (mode == MODE_FIRST_A) || (mode == MODE_FIRST_B);
    assign is_second = (mode == MODE_SECOND_A) || (mode == MODE_SECOND_B);
    assign is_off    = (cmd_in[3][4:2] == 3'b000);

    // Classify and merge in one pass; state and queue write move together.
    always_comb begin
        n_active = r_active;
        n_first  = r_first;
        n_second = r_second;
        cmd_mid  = cmd_in;
        o_cmd    = cmd_in;
        if (cmd_in[0] == 8'h00) begin
            if (is_off) begin
                n_active = r_active & ~{is_second, is_first};
                if (n_active != 2'b00) begin
                    cmd_mid = (n_active == 2'b01) ? r_first : r_second;
                end
            end else begin
                n_active = r_active | {is_second, is_first};
                if (is_first) begin
                    n_first = cmd_in;
                end
                if (is_second) begin
                    n_second = cmd_in;
                end
            end
            o_cmd = cmd_mid;
            if (n_active == 2'b11) begin
                o_cmd[1] = n_second[1];
                o_cmd[2] = {n_first[2][7:1], n_second[2][0]};
                o_cmd[3] = {MODE_MERGED, cmd_mid[3][4:2], n_first[3][1:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 2'b00;
            r_first  <= '0;
            r_second <= '0;
        end else if (o_push) begin
            r_active <= n_active;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

endmodule

// ===== rtl/core/lcmf_queue.sv =====
module lcmf_queue
    import lcmf_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty,
    output logic o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;
    logic [CW-1:0] n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/lcmf_back.sv =====
module lcmf_back
    import lcmf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_head,
    output logic        o_pop,
    lcmf_frame_if.source o_frame
);

    logic        r_busy;
    t_fidx       r_idx;
    t_cmd        r_cmd;
    logic [15:0] r_crc;
    logic        n_busy;
    t_fidx       n_idx;
    t_cmd        n_cmd;
    logic [15:0] n_crc;

    logic        fire;
    logic        last;
    logic [1:0]  crc_sel;

    assign last    = (r_idx == IDX_CMD3);
    assign fire    = r_busy && o_frame.ready;
    assign o_pop   = !i_empty && (!r_busy || (fire && last));
    assign crc_sel = r_idx[1:0] + 2'd1;

    // Load a command on pop; fold command byte 0 into the CRC on load and bytes 1 and 2 as the sync bytes are sent.
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_cmd  = r_cmd;
        n_crc  = r_crc;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = IDX_SYNC0;
            n_cmd  = i_head;
            n_crc  = crc_step(CRC_PRE, i_head[0]);
        end else if (fire) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
            if (r_idx < IDX_LEN) begin
                n_crc = crc_step(r_crc, r_cmd[crc_sel]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= IDX_SYNC0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_crc <= n_crc;
    end

    always_comb begin
        case (r_idx)
            IDX_SYNC0:  o_frame.frame_byte = SYNC0_BYTE;
            IDX_SYNC1:  o_frame.frame_byte = SYNC1_BYTE;
            IDX_LEN:    o_frame.frame_byte = LEN_BYTE;
            IDX_CRC_LO: o_frame.frame_byte = r_crc[7:0];
            IDX_CRC_HI: o_frame.frame_byte = r_crc[15:8];
            IDX_PAD0:   o_frame.frame_byte = PAD_BYTE;
            IDX_PAD1:   o_frame.frame_byte = PAD_BYTE;
            IDX_TAG:    o_frame.frame_byte = TAG_BYTE;
            IDX_CMD0:   o_frame.frame_byte = r_cmd[0];
            IDX_CMD1:   o_frame.frame_byte = r_cmd[1];
            IDX_CMD2:   o_frame.frame_byte = r_cmd[2];
            IDX_CMD3:   o_frame.frame_byte = r_cmd[3];
            default:    o_frame.frame_byte = PAD_BYTE;
        endcase
    end

    assign o_frame.valid      = r_busy;
    assign o_frame.frame_last = last;

endmodule

// ===== rtl/core/led_command_merge_framer_top.sv =====
// LED command framer: takes one four-byte LED command word and sends a 12-byte frame,
// one byte per output word: 59 A5 0A, CRC low, CRC high, 00 00 01, then the four
// command bytes, with frame_last on the final byte. The CRC is CRC-16/MODBUS over
// frame bytes 5 to 10 (the fixed 00 00 01 and command bytes 0 to 2). A command whose
// byte 0 is zero goes through LED merge handling: "on" commands in modes 1/6 and 0/5
// are saved and flagged, "off" commands clear their flag and fall back to the other
// saved command, and with both flags set the two saved commands are merged into one
// mode-4 command. The output carries one byte per cycle while ready is high, and frames
// follow each other with no gap when the next command is already queued. An accepted
// command is first written into the queue and then loaded into the framer before its
// first frame byte can be taken. Up to QUEUE_DEPTH merged commands wait between the
// merge stage and the framer, so input is taken while a frame is out.
module led_command_merge_framer_top
    import lcmf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lcmf_cmd_if.sink     i_cmd,
    lcmf_frame_if.source o_frame
);

    // Merged command words between the merge stage and the framer.
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Merge stage: hold LED state, classify each command, write the queue.
    lcmf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Short queue: let either side stall on its own.
    lcmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Framer: advance one byte per accepted output word, fold CRC on the way.
    lcmf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_frame (o_frame)
    );

endmodule

// ===== rtl/core/lcmf_checker.sv =====
`include "led_command_merge_framer_top_assert.svh"

module lcmf_checker
    import lcmf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_frame_byte,
    input logic       i_frame_last
);

    t_fidx r_pos;
    t_fidx n_pos;
    logic  fire;

    assign fire = i_out_valid && i_out_ready;

    always_comb begin
        n_pos = r_pos;
        if (fire) begin
            n_pos = (r_pos == IDX_CMD3) ? IDX_SYNC0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= IDX_SYNC0;
        end else begin
            r_pos <= n_pos;
        end
    end

    `LCMF_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_frame_byte))
    `LCMF_ASSERT_NOW(a_last_pos, i_out_valid, i_frame_last == (r_pos == IDX_CMD3))
    `LCMF_ASSERT_NOW(a_sync_first, i_out_valid && (r_pos == IDX_SYNC0), i_frame_byte == SYNC0_BYTE)
    `LCMF_ASSERT_NOW(a_tag_byte, i_out_valid && (r_pos == IDX_TAG), i_frame_byte == TAG_BYTE)

endmodule

bind led_command_merge_framer_top lcmf_checker u_lcmf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_frame.valid),
    .i_out_ready  (o_frame.ready),
    .i_frame_byte (o_frame.frame_byte),
    .i_frame_last (o_frame.frame_last)
);

// ===== bench/tb_top.sv =====
module tb_top;
    import lcmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // On/off intensity field of command byte 3; zero means an off command.
    localparam logic [7:0] LEVEL_MASK = 8'h1C;

    // Random items after the directed opening.
    localparam int RANDOM_CMDS = 150;
    // Cycle window with no idling on either side.
    localparam int CALM_FROM = 900;
    localparam int CALM_TO   = 1500;
    // Settle time after the last expected byte.
    localparam int TAIL_CYCLES = 24;

    typedef struct {
        t_cmd cmd;
        bit   drain;   // hold this word until every expected byte has come back
    } led_cmd_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lcmf_cmd_if   cmd_bus ();
    lcmf_frame_if frame_bus ();

    led_command_merge_framer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_frame (frame_bus)
    );

    // Period 12 ns.
    always begin
        #6ns i_clk = 1'b1;
        #6ns i_clk = 1'b0;
    end

    led_cmd_item_t led_cmds_to_send[$];
    frame_byte_t   frame_bytes_due[$];
    t_cmd          cmd_in_flight;
    int            mismatch_count = 0;
    int            cycle_count = 0;

    // Predictor state: active flags and the two saved "on" commands.
    logic [1:0] led_on;
    t_cmd       first_cmd;
    t_cmd       second_cmd;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Randomly idle in about 23 percent of cycles, except in the calm window.
    function automatic bit take_break(input int cyc);
        if (cyc >= CALM_FROM && cyc < CALM_TO) begin
            return 1'b0;
        end
        return $urandom_range(99) < 23;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    // CRC-16/MODBUS: init FFFF, reflected poly A001, no final xor.
    function automatic logic [15:0] modbus_crc(input logic [7:0] body[6]);
        logic [15:0] acc;
        acc = 16'hFFFF;
        for (int i = 0; i < 6; i++) begin
            acc ^= {8'h00, body[i]};
            for (int k = 0; k < 8; k++) begin
                acc = acc[0] ? ((acc >> 1) ^ 16'hA001) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    // Apply merge handling to one accepted command, advance the flags and saved
    // commands, and queue the twelve frame bytes it must produce.
    function automatic void build_led_frame(input t_cmd raw);
        t_cmd        cmd;
        logic [2:0]  mode;
        bit          is_first;
        bit          is_second;
        logic [7:0]  body[6];
        logic [15:0] crc;
        logic [7:0]  fr[12];
        frame_byte_t fb;
        cmd = raw;
        if (cmd[0] == 8'h00) begin
            mode      = cmd[3][7:5];
            is_first  = (mode == MODE_FIRST_A) || (mode == MODE_FIRST_B);
            is_second = (mode == MODE_SECOND_A) || (mode == MODE_SECOND_B);
            if ((cmd[3] & LEVEL_MASK) == 8'h00) begin
                // Off: drop the own flag, fall back to what is still active.
                if (is_first) led_on[0] = 1'b0;
                if (is_second) led_on[1] = 1'b0;
                if (led_on != 2'b00) begin
                    cmd = (led_on == 2'b01) ? first_cmd : second_cmd;
                end
            end else begin
                // On: raise the own flag and remember the command.
                if (is_first) begin
                    led_on[0] = 1'b1;
                    first_cmd = cmd;
                end
                if (is_second) begin
                    led_on[1] = 1'b1;
                    second_cmd = cmd;
                end
            end
            if (led_on == 2'b11) begin
                cmd[1] = second_cmd[1];
                cmd[2] = {first_cmd[2][7:1], second_cmd[2][0]};
                cmd[3] = {MODE_MERGED, cmd[3][4:2], first_cmd[3][1:0]};
            end
        end
        body = '{PAD_BYTE, PAD_BYTE, TAG_BYTE, cmd[0], cmd[1], cmd[2]};
        // The CRC covers bytes 5..10: pads, tag and command bytes 0..2.
        crc = modbus_crc(body);
        fr = '{SYNC0_BYTE, SYNC1_BYTE, LEN_BYTE, crc[7:0], crc[15:8],
               PAD_BYTE, PAD_BYTE, TAG_BYTE, cmd[0], cmd[1], cmd[2], cmd[3]};
        for (int i = 0; i < 12; i++) begin
            fb.data = fr[i];
            fb.last = (i == 11);
            frame_bytes_due.push_back(fb);
        end
    endfunction

    task automatic queue_cmd(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input bit drain = 1'b0);
        led_cmd_item_t it;
        it.cmd   = {b3, b2, b1, b0};
        it.drain = drain;
        led_cmds_to_send.push_back(it);
    endtask

    // Driver: predict on acceptance, then present the next word or idle.
    always @(posedge i_clk) begin : drive_cmds
        led_cmd_item_t nxt;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                build_led_frame(cmd_in_flight);
            end
            if (!cmd_bus.valid || cmd_bus.ready) begin
                if (led_cmds_to_send.size() != 0 && !take_break(cycle_count) &&
                    (!led_cmds_to_send[0].drain || frame_bytes_due.size() == 0)) begin
                    nxt = led_cmds_to_send.pop_front();
                    cmd_in_flight = nxt.cmd;
                    cmd_bus.valid     <= 1'b1;
                    cmd_bus.cmd_byte0 <= nxt.cmd[0];
                    cmd_bus.cmd_byte1 <= nxt.cmd[1];
                    cmd_bus.cmd_byte2 <= nxt.cmd[2];
                    cmd_bus.cmd_byte3 <= nxt.cmd[3];
                end else begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted frame byte against the oldest expectation.
    always @(posedge i_clk) begin : watch_frames
        frame_byte_t want;
        if (!i_rst_n) begin
            frame_bus.ready <= 1'b0;
        end else begin
            if (frame_bus.valid && frame_bus.ready) begin
                if (frame_bytes_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected frame byte %h last %b",
                                            frame_bus.frame_byte, frame_bus.frame_last));
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (frame_bus.frame_byte !== want.data) begin
                        flag_mismatch($sformatf("frame_byte %h, expected %h",
                                                frame_bus.frame_byte, want.data));
                    end
                    if (frame_bus.frame_last !== want.last) begin
                        flag_mismatch($sformatf("frame_last %b, expected %b",
                                                frame_bus.frame_last, want.last));
                    end
                end
            end
            frame_bus.ready <= !take_break(cycle_count);
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [7:0] b0;
        logic [2:0] mode;
        logic [2:0] level;
        logic [2:0] key_modes[4];

        key_modes = '{MODE_SECOND_A, MODE_FIRST_A, MODE_SECOND_B, MODE_FIRST_B};
        led_on     = 2'b00;
        first_cmd  = '0;
        second_cmd = '0;
        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.cmd_byte0  = 8'h00;
        cmd_bus.cmd_byte1  = 8'h00;
        cmd_bus.cmd_byte2  = 8'h00;
        cmd_bus.cmd_byte3  = 8'h00;
        frame_bus.ready    = 1'b0;

        // Pass-through with nonzero byte 0, all-ones and a single bit.
        queue_cmd(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_cmd(8'h01, 8'h00, 8'h00, 8'h00);
        // Second-mode off with nothing active: framed as is.
        queue_cmd(8'h00, 8'h00, 8'h00, 8'h00);
        // First-mode on, then second-mode on: both active, merged.
        queue_cmd(8'h00, 8'h12, 8'h35, {MODE_FIRST_A, 3'd7, 2'b11});
        queue_cmd(8'h00, 8'hAB, 8'hCD, {MODE_SECOND_A, 3'd1, 2'b00});
        // Second off leaves first alone: restore the saved first command.
        queue_cmd(8'h00, 8'hFF, 8'hFF, {MODE_SECOND_B, 3'd0, 2'b11});
        // Second on again, full intensity: merge.
        queue_cmd(8'h00, 8'h55, 8'hAA, {MODE_SECOND_B, 3'd7, 2'b00});
        // Off in an unrelated mode while both are active: restore second, merge.
        queue_cmd(8'h00, 8'h00, 8'h00, {3'd2, 3'd0, 2'b10}, 1'b1);
        // First off (both first modes): only second left, restore it.
        queue_cmd(8'h00, 8'h3C, 8'hC3, {MODE_FIRST_B, 3'd0, 2'b01});
        queue_cmd(8'h00, 8'h00, 8'h00, {MODE_FIRST_A, 3'd0, 2'b00});
        // Second off: nothing active any more.
        queue_cmd(8'h00, 8'h80, 8'h01, {MODE_SECOND_B, 3'd0, 2'b00});
        // First on, then on commands in modes without a flag and an all-ones word.
        queue_cmd(8'h00, 8'hFE, 8'h7F, {MODE_FIRST_B, 3'd7, 2'b11});
        queue_cmd(8'h00, 8'h11, 8'h22, {MODE_MERGED, 3'd7, 2'b11});
        queue_cmd(8'h00, 8'h33, 8'h44, {3'd3, 3'd4, 2'b01});
        queue_cmd(8'h00, 8'h66, 8'h77, {3'd7, 3'd2, 2'b00});
        queue_cmd(8'h00, 8'hFF, 8'hFF, 8'hFF);
        // Nonzero byte 0 with merge-looking bytes: state untouched.
        queue_cmd(8'h80, 8'h00, 8'hFF, {MODE_SECOND_A, 3'd0, 2'b00});
        queue_cmd(8'h00, 8'h01, 8'h80, {MODE_SECOND_A, 3'd3, 2'b10});

        // Random part: mostly merge-path commands in the flagged modes.
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            b0 = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'h00;
            if ($urandom_range(3) != 0) begin
                mode = key_modes[$urandom_range(3)];
            end else begin
                mode = 3'($urandom_range(7));
            end
            level = ($urandom_range(99) < 35) ? 3'd0 : 3'($urandom_range(7, 1));
            queue_cmd(b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      {mode, level, 2'($urandom_range(3))}, (n % 37) == 36);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every word to go in and every frame byte to come out; sample
        // away from the active edge so the driver has settled.
        while (led_cmds_to_send.size() != 0 || cmd_bus.valid ||
               frame_bytes_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #3ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
